// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the interpolator.
// Each macro takes a label, the clock, the active-low reset and an expression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define AST_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
	else $error("forbidden condition seen");
`else
`define AST_PROP(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/tai_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed angle interpolator package
// Widths, operation codes, table entry and divider request and response types.
// ----------------------------------------------------------------------------
package tai_pkg;

	localparam int CHANNELS  = 64;
	localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHANNEL_W = 6;
	localparam int OP_W      = 3;
	localparam int VAL_W     = 16;
	localparam int TIME_W    = 32;
	localparam int RES_W     = 32;

	localparam logic [OP_W-1:0] OP_SET_MASKED = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_RAW    = 3'd1;
	localparam logic [OP_W-1:0] OP_MOVE       = 3'd2;
	localparam logic [OP_W-1:0] OP_ANGLE_QRY  = 3'd3;
	localparam logic [OP_W-1:0] OP_VALUE_QRY  = 3'd4;

	localparam logic [VAL_W-1:0] ANGLE_MASK = 16'h03FF;
	localparam logic signed [16:0] HALF_TURN = 17'sh00200;
	localparam logic signed [16:0] FULL_TURN = 17'sh00400;

	typedef struct packed {
		logic [VAL_W-1:0]  from_val;
		logic [VAL_W-1:0]  to_val;
		logic [VAL_W-1:0]  steps;
		logic [TIME_W-1:0] start_time;
	} entry_t;

	typedef struct packed {
		logic                    start;
		logic signed [RES_W-1:0] dividend;
		logic signed [VAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [RES_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tai_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolator channel interfaces
// Valid/ready channels for operation items and query results.
// ----------------------------------------------------------------------------
interface tai_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [tai_pkg::OP_W-1:0]             operation;
	logic [tai_pkg::CHANNEL_W-1:0]        channel;
	logic signed [tai_pkg::TIME_W-1:0]    now;
	logic signed [tai_pkg::VAL_W-1:0]     start_value;
	logic signed [tai_pkg::VAL_W-1:0]     end_value;
	logic signed [tai_pkg::VAL_W-1:0]     step_count;
	logic [tai_pkg::VAL_W-1:0]            speed;

	modport source (output valid, operation, channel, now, start_value, end_value,
		step_count, speed, input ready);
	modport sink (input valid, operation, channel, now, start_value, end_value,
		step_count, speed, output ready);
endinterface

interface tai_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tai_pkg::RES_W-1:0]  result_value;
	logic                              finished;

	modport source (output valid, result_value, finished, input ready);
	modport sink (input valid, result_value, finished, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tai_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division, one quotient bit per cycle, truncating towards zero.
// ----------------------------------------------------------------------------
module tai_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tai_pkg::div_req_t req,
	output tai_pkg::div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(tai_pkg::RES_W);

	logic                       busy_q;
	logic                       done_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [tai_pkg::VAL_W-1:0]  rem_q;
	logic [tai_pkg::VAL_W:0]    dvs_q;
	logic [tai_pkg::RES_W-1:0]  shr_q;

	logic [tai_pkg::VAL_W:0]    rem_sh;
	logic [tai_pkg::VAL_W:0]    diff;
	logic                       fits;
	logic [tai_pkg::RES_W-1:0]  dvd_abs;
	logic [tai_pkg::VAL_W:0]    dvs_abs;

	assign rem_sh  = {rem_q, shr_q[tai_pkg::RES_W-1]};
	assign diff    = rem_sh - dvs_q;
	assign fits    = (rem_sh >= dvs_q);
	assign dvd_abs = req.dividend[tai_pkg::RES_W-1] ? (tai_pkg::RES_W'(0) - req.dividend)
		: req.dividend;
	assign dvs_abs = req.divisor[tai_pkg::VAL_W-1]
		? ((tai_pkg::VAL_W+1)'(0) - {req.divisor[tai_pkg::VAL_W-1], req.divisor})
		: {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(tai_pkg::RES_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			shr_q <= dvd_abs;
			dvs_q <= dvs_abs;
			neg_q <= req.dividend[tai_pkg::RES_W-1] ^ req.divisor[tai_pkg::VAL_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[tai_pkg::VAL_W-1:0] : rem_sh[tai_pkg::VAL_W-1:0];
			shr_q <= {shr_q[tai_pkg::RES_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (tai_pkg::RES_W'(0) - shr_q) : shr_q;

	`AST_NEVER(a_start_while_busy, clk, arst_n, req.start && busy_q)
	`AST_PROP(a_done_single, clk, arst_n, done_q |=> !done_q)
	`AST_PROP(a_done_after_last, clk, arst_n, done_q |-> $past(busy_q) && !busy_q)

endmodule
`default_nettype wire

// ===== hw/rtl/timed_angle_interpolator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Steps: a set or move reads its entry at the transfer and writes it in the read state; a
// query goes from the read state to the done state if its transition has finished, else
// through the multiply, divider start and divider states first; from the done state its
// result moves to the output register once that register is free.
// Flow: one item at a time; the next item is taken once the control returns to idle.
// Reset: asynchronous, clears control state and the per-channel valid bits, so every entry
// reads as zero until written.
// ----------------------------------------------------------------------------
// Timed angle interpolator core
// Table of timed transitions with set, move and interpolating queries.
// ----------------------------------------------------------------------------
module timed_angle_interpolator_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tai_in_if.sink     req,
	tai_out_if.source  rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DST  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	tai_pkg::entry_t                      mem [tai_pkg::CHANNELS];
	logic [tai_pkg::CHANNELS-1:0]         valid_q;
	tai_pkg::entry_t                      rd_entry_s1;
	logic                                 rd_valid_s1;

	logic [2:0]                           state_q;
	logic [tai_pkg::OP_W-1:0]             op_q;
	logic [tai_pkg::ADDR_W-1:0]           addr_q;
	logic signed [tai_pkg::TIME_W-1:0]    now_q;
	logic [tai_pkg::VAL_W-1:0]            sv_q;
	logic [tai_pkg::VAL_W-1:0]            ev_q;
	logic [tai_pkg::VAL_W-1:0]            sc_q;
	logic [tai_pkg::VAL_W-1:0]            speed_q;

	logic signed [16:0]                   d_q;
	logic signed [tai_pkg::TIME_W-1:0]    elapsed_q;
	logic signed [tai_pkg::VAL_W-1:0]     steps_q;
	logic signed [tai_pkg::VAL_W-1:0]     from_q;
	logic signed [tai_pkg::RES_W-1:0]     prod_q;

	logic                                 out_valid_q;
	logic signed [tai_pkg::RES_W-1:0]     res_q;
	logic                                 fin_q;
	logic signed [tai_pkg::RES_W-1:0]     out_value_q;
	logic                                 out_fin_q;

	logic                                 accept;
	logic                                 ch_ok;
	tai_pkg::entry_t                      cur;
	logic                                 mem_we;
	tai_pkg::entry_t                      wr_entry;
	logic signed [tai_pkg::TIME_W-1:0]    elapsed;
	logic signed [16:0]                   d_raw;
	logic signed [16:0]                   d_adj;
	logic                                 ends_now;
	logic [9:0]                           mv_diff;
	logic [9:0]                           mv_mag;
	logic [25:0]                          mv_prod;
	logic signed [48:0]                   mul_full;
	logic                                 out_free;
	tai_pkg::div_req_t                    div_req;
	tai_pkg::div_rsp_t                    div_rsp;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign ch_ok = (32'(addr_q) < tai_pkg::CHANNELS);
	assign cur = rd_valid_s1 ? rd_entry_s1 : '0;

	// The table is read at the input transfer and written in the following cycle; the
	// next read cannot happen before the write has landed, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= wr_entry;
		end
		if (accept) begin
			rd_entry_s1 <= mem[tai_pkg::ADDR_W'(req.channel)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (accept) begin
				rd_valid_s1 <= valid_q[tai_pkg::ADDR_W'(req.channel)];
			end
		end
	end

	assign elapsed  = now_q - signed'(cur.start_time);
	assign ends_now = (cur.steps == '0) ||
		(elapsed >= tai_pkg::TIME_W'(signed'(cur.steps)));
	assign d_raw    = 17'(signed'(cur.to_val)) - 17'(signed'(cur.from_val));
	always_comb begin
		d_adj = d_raw;
		if (op_q == tai_pkg::OP_ANGLE_QRY) begin
			if (d_raw < -tai_pkg::HALF_TURN) begin
				d_adj = d_raw + tai_pkg::FULL_TURN;
			end else if (d_raw > tai_pkg::HALF_TURN) begin
				d_adj = d_raw - tai_pkg::FULL_TURN;
			end
		end
	end

	assign mv_diff = sv_q[9:0] - ev_q[9:0];
	assign mv_mag  = mv_diff[9] ? (10'd0 - mv_diff) : mv_diff;
	assign mv_prod = 26'(mv_mag) * 26'(speed_q);

	always_comb begin
		mem_we   = 1'b0;
		wr_entry = cur;
		if (state_q == S_RD && ch_ok) begin
			case (op_q)
				tai_pkg::OP_SET_MASKED: begin
					mem_we   = 1'b1;
					wr_entry = '{sv_q & tai_pkg::ANGLE_MASK, ev_q & tai_pkg::ANGLE_MASK,
						sc_q & tai_pkg::ANGLE_MASK, now_q};
				end
				tai_pkg::OP_SET_RAW: begin
					mem_we   = 1'b1;
					wr_entry = '{sv_q, ev_q, sc_q, now_q};
				end
				tai_pkg::OP_MOVE: begin
					mem_we   = 1'b1;
					wr_entry = '{sv_q & tai_pkg::ANGLE_MASK, ev_q & tai_pkg::ANGLE_MASK,
						mv_prod[23:8], now_q};
				end
				tai_pkg::OP_ANGLE_QRY, tai_pkg::OP_VALUE_QRY: begin
					mem_we         = ends_now;
					wr_entry.steps = '0;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	assign mul_full = 49'(d_q) * 49'(elapsed_q);
	assign out_free = !out_valid_q || rsp.ready;

	assign div_req.start    = (state_q == S_DST);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = steps_q;

	tai_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (ch_ok && (op_q == tai_pkg::OP_ANGLE_QRY ||
						op_q == tai_pkg::OP_VALUE_QRY)) begin
						state_q <= ends_now ? S_DONE : S_MUL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					state_q <= S_DST;
				end
				S_DST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			addr_q  <= tai_pkg::ADDR_W'(req.channel);
			now_q   <= req.now;
			sv_q    <= req.start_value;
			ev_q    <= req.end_value;
			sc_q    <= req.step_count;
			speed_q <= req.speed;
		end
		if (state_q == S_RD) begin
			d_q       <= d_adj;
			elapsed_q <= elapsed;
			steps_q   <= signed'(cur.steps);
			from_q    <= signed'(cur.from_val);
			res_q     <= tai_pkg::RES_W'(signed'(cur.to_val));
			fin_q     <= 1'b1;
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_full[tai_pkg::RES_W-1:0];
		end
		if (state_q == S_DIV && div_rsp.done) begin
			res_q <= div_rsp.quotient + tai_pkg::RES_W'(from_q);
			fin_q <= 1'b0;
		end
		if (state_q == S_DONE && out_free) begin
			out_value_q <= res_q;
			out_fin_q   <= fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.finished     = out_fin_q;

	`AST_PROP(a_rd_after_transfer, clk, arst_n, state_q == S_RD |-> $past(accept))
	`AST_PROP(a_div_done_waited, clk, arst_n, div_rsp.done |-> state_q == S_DIV)
	`AST_NEVER(a_start_div_busy, clk, arst_n, div_req.start && div_rsp.busy)
	`AST_PROP(a_write_in_rd, clk, arst_n, mem_we |-> state_q == S_RD && !accept)

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed angle interpolator testbench
// Drives set, move, query and reserved operations into the core over its
// valid/ready channels. It keeps its own model of the transition table and
// checks every query result, in order, against the model. The stimulus
// covers directed corner cases, random transition sequences under three
// idling patterns, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import tai_pkg::*;

	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 400;
	localparam int LATENCY_TAIL = 64;

	typedef struct packed {
		logic signed [RES_W-1:0] value;
		logic                    finished;
	} query_result_t;

	logic clk = 1'b0;
	logic arst_n;

	tai_in_if  in_ch ();
	tai_out_if out_ch ();

	timed_angle_interpolator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_ch),
		.rsp    (out_ch)
	);

	logic [VAL_W-1:0]  from_tab  [CHANNELS];
	logic [VAL_W-1:0]  to_tab    [CHANNELS];
	logic [VAL_W-1:0]  steps_tab [CHANNELS];
	logic [TIME_W-1:0] start_tab [CHANNELS];

	query_result_t pending_results [$];
	int error_count   = 0;
	int items_sent    = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Applies one operation to the table copy; returns 1 when a query result is due.
	function automatic bit advance_transition_table(input logic [OP_W-1:0] op,
			input logic [CHANNEL_W-1:0] ch, input logic [TIME_W-1:0] t_now,
			input logic [VAL_W-1:0] sv, ev, sc, spd, output query_result_t res);
		logic [9:0] gap;
		longint mag, d, el, st, fr, tgt, prod, quo;
		int prod32;
		res = '0;
		case (op)
			OP_SET_MASKED: begin
				from_tab[ch]  = sv & ANGLE_MASK;
				to_tab[ch]    = ev & ANGLE_MASK;
				steps_tab[ch] = sc & ANGLE_MASK;
				start_tab[ch] = t_now;
				return 1'b0;
			end
			OP_SET_RAW: begin
				from_tab[ch]  = sv;
				to_tab[ch]    = ev;
				steps_tab[ch] = sc;
				start_tab[ch] = t_now;
				return 1'b0;
			end
			OP_MOVE: begin
				from_tab[ch] = sv & ANGLE_MASK;
				to_tab[ch]   = ev & ANGLE_MASK;
				gap = sv[9:0] - ev[9:0];
				mag = longint'($signed(gap));
				if (mag < 0)
					mag = -mag;
				prod = (mag * longint'(spd)) >>> 8;
				steps_tab[ch] = prod[15:0];
				start_tab[ch] = t_now;
				return 1'b0;
			end
			OP_ANGLE_QRY, OP_VALUE_QRY: begin
				st  = longint'($signed(steps_tab[ch]));
				tgt = longint'($signed(to_tab[ch]));
				fr  = longint'($signed(from_tab[ch]));
				el  = longint'($signed(t_now - start_tab[ch]));
				if (st == 0 || el >= st) begin
					steps_tab[ch] = '0;
					res.value    = tgt[31:0];
					res.finished = 1'b1;
					return 1'b1;
				end
				d = tgt - fr;
				if (op == OP_ANGLE_QRY) begin
					if (d < -longint'(HALF_TURN))
						d = d + longint'(FULL_TURN);
					else if (d > longint'(HALF_TURN))
						d = d - longint'(FULL_TURN);
				end
				prod   = d * el;
				prod32 = prod[31:0];
				quo    = longint'(prod32) / st;
				res.value    = quo[31:0] + fr[31:0];
				res.finished = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [CHANNEL_W-1:0] ch,
			input logic [TIME_W-1:0] t_now, input logic [VAL_W-1:0] sv, ev, sc, spd);
		query_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.operation   <= op;
		in_ch.channel     <= ch;
		in_ch.now         <= t_now;
		in_ch.start_value <= sv;
		in_ch.end_value   <= ev;
		in_ch.step_count  <= sc;
		in_ch.speed       <= spd;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		if (advance_transition_table(op, ch, t_now, sv, ev, sc, spd, res))
			pending_results.push_back(res);
		if (op <= OP_VALUE_QRY)
			items_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// A set or move on one entry followed by one to four queries of that entry.
	task automatic run_transition_sequence();
		logic [CHANNEL_W-1:0] ch;
		logic [OP_W-1:0] op;
		logic [TIME_W-1:0] t0;
		logic [VAL_W-1:0] sc, spd;
		longint st, el;
		ch = ($urandom_range(99) < 60) ? 6'($urandom_range(7)) : 6'($urandom);
		case ($urandom_range(2))
			0: op = OP_SET_MASKED;
			1: op = OP_SET_RAW;
			default: op = OP_MOVE;
		endcase
		case ($urandom_range(9))
			0: sc = 16'h0000;
			1: sc = 16'h8000 | 16'($urandom);
			2, 3: sc = 16'($urandom);
			default: sc = 16'($urandom_range(1, 600));
		endcase
		case ($urandom_range(9))
			0: spd = 16'h0000;
			1: spd = 16'hFFFF;
			2, 3, 4: spd = 16'($urandom_range(1, 512));
			default: spd = 16'($urandom);
		endcase
		t0 = $urandom;
		send_item(op, ch, t0, pick_value(), pick_value(), sc, spd);
		st = longint'($signed(steps_tab[ch]));
		el = 0;
		repeat ($urandom_range(1, 4)) begin
			if (st > 0)
				el = el + $urandom_range(0, int'(st / 3) + 1);
			else if (st < 0)
				el = st - 1 - $urandom_range(0, 5000);
			else
				el = $urandom_range(0, 50);
			send_item($urandom_range(1) ? OP_ANGLE_QRY : OP_VALUE_QRY, ch, t0 + el[31:0],
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_item(OP_VALUE_QRY, 6'd0, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_SET_MASKED, 6'd1, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_VALUE_QRY, 6'd1, 32'd10, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_SET_RAW, 6'd2, 32'h7FFF_FFF0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0);
		send_item(OP_VALUE_QRY, 6'd2, 32'h7FFF_FFF0 + 32'd1000, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_ANGLE_QRY, 6'd2, 32'h7FFF_FFF0 + 32'd1000, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_VALUE_QRY, 6'd2, 32'h7FFF_FFF0 + 32'd32767, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_VALUE_QRY, 6'd2, 32'h7FFF_FFF0, 16'h0, 16'h0, 16'h0, 16'h0);
		// Most negative product over a step count of minus one.
		send_item(OP_SET_RAW, 6'd3, 32'd0, 16'h0000, 16'h0001, 16'hFFFF, 16'h0);
		send_item(OP_ANGLE_QRY, 6'd3, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'h0);
		// Product that overflows 32 bits with a negative step count.
		send_item(OP_SET_RAW, 6'd4, 32'd0, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h0);
		send_item(OP_VALUE_QRY, 6'd4, 32'hC000_0000, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_SET_MASKED, 6'd5, 32'd5, 16'd1000, 16'd0, 16'd100, 16'h0);
		send_item(OP_ANGLE_QRY, 6'd5, 32'd55, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_SET_MASKED, 6'd6, 32'd0, 16'd0, 16'd600, 16'd200, 16'h0);
		send_item(OP_ANGLE_QRY, 6'd6, 32'd100, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_MOVE, 6'd7, 32'd0, 16'd0, 16'd512, 16'h0, 16'hFFFF);
		send_item(OP_ANGLE_QRY, 6'd7, 32'hFFFF_FF00, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_MOVE, 6'd8, 32'd0, 16'h03FF, 16'h0000, 16'h0, 16'h0000);
		send_item(OP_VALUE_QRY, 6'd8, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_MOVE, 6'd9, 32'd40, 16'd100, 16'd400, 16'h0, 16'd256);
		send_item(OP_ANGLE_QRY, 6'd9, 32'd190, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_RSVD_5, 6'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_RSVD_6, 6'd1, 32'd0, 16'h1234, 16'h4321, 16'h0001, 16'h0001);
		send_item(OP_RSVD_7, 6'd1, 32'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_VALUE_QRY, 6'd1, 32'd20, 16'h0, 16'h0, 16'h0, 16'h0);
		send_item(OP_SET_MASKED, 6'd63, 32'hFFFF_FFFF, 16'd0, 16'd1023, 16'd16, 16'h0);
		send_item(OP_VALUE_QRY, 6'd63, 32'h0000_0005, 16'h0, 16'h0, 16'h0, 16'h0);
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(99) < 80)
				run_transition_sequence();
			else
				send_item(3'($urandom), 6'($urandom), $urandom, pick_value(), pick_value(),
					16'($urandom), 16'($urandom));
		end
		wait_results_drained();
	endtask

	task automatic test_output_backpressure();
		int target;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		target = items_sent + 40;
		while (items_sent < target)
			run_transition_sequence();
		wait_results_drained();
	endtask

	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen     <= hold_requests;
			hold_left     <= LONG_HOLD;
			out_ch.ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		query_result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result without a query: result_value %0d, finished %0b",
					out_ch.result_value, out_ch.finished);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.result_value !== want.value) begin
					$error("result_value mismatch: expected %0d, actual %0d",
						want.value, out_ch.result_value);
					error_count++;
				end
				if (out_ch.finished !== want.finished) begin
					$error("finished mismatch: expected %0b, actual %0b",
						want.finished, out_ch.finished);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.operation   = OP_SET_MASKED;
		in_ch.channel     = '0;
		in_ch.now         = '0;
		in_ch.start_value = '0;
		in_ch.end_value   = '0;
		in_ch.step_count  = '0;
		in_ch.speed       = '0;
		out_ch.ready      = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			from_tab[i]  = '0;
			to_tab[i]    = '0;
			steps_tab[i] = '0;
			start_tab[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_traffic(9, 77, 530);
		test_random_traffic(77, 9, 530);
		test_random_traffic(0, 0, 530);
		test_output_backpressure();

		repeat (LATENCY_TAIL) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tai_pkg.sv
hw/rtl/tai_if.sv
hw/rtl/tai_div.sv
hw/rtl/timed_angle_interpolator_core.sv
verif/testbench.sv
